/* rtl/core/pfdjr_pkg.sv */
// types, constants and helper functions of the per-flow delay, jitter and rate monitor
package pfdjr_pkg;

  localparam int unsigned FlowCountDef = 32;
  localparam int unsigned InDataW      = 120;
  localparam int unsigned OutDataW     = 136;
  localparam int unsigned QuotW        = 42;
  localparam int unsigned DivCntW      = 6;
  localparam logic [9:0]  MsPerSec     = 10'd1000;
  localparam logic [31:0] MsRecip      = 32'h8312_6e98;
  localparam logic [30:0] RateMax      = 31'h7fff_ffff;
  localparam logic [31:0] CountMax     = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_TX    = 2'd1,
    OP_CLOSE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MSDIV,
    ST_RD,
    ST_EXEC,
    ST_RXB,
    ST_RDIV,
    ST_TDIV,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0]        rx_cnt;
    logic [31:0]        tx_cnt;
    logic [33:0]        rx_avg;
    logic [33:0]        tx_avg;
    logic signed [34:0] dly_avg;
    logic [34:0]        jit_avg;
  } row_t;

  function automatic logic signed [34:0] quarter_s(input logic signed [34:0] v);
    logic signed [34:0] b;
    b = v + (v[34] ? 35'sd3 : 35'sd0);
    return b >>> 2;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? CountMax : s[31:0];
  endfunction

  function automatic logic [30:0] sat31(input logic [32:0] v);
    return (v > {2'b0, RateMax}) ? RateMax : v[30:0];
  endfunction

endpackage

/* rtl/core/per_flow_delay_jitter_rate_stats.sv */
// Per-flow traffic monitor: delay and jitter averages, byte counts and rate averages for each flow.
// Each event is handled in full before the next is accepted, and a read event also waits until
// its report is taken. All flow statistics live in one table read through a registered port. A
// close-interval event first turns the interval into ms with one reciprocal multiplication, then
// for each flow divides both byte counts times 1000 by the interval in ms; these divisions run
// on one shared restoring divider that yields one quotient bit per cycle, and each flow's report
// of a close also waits for the output handshake.
// The table needs no clearing pass after reset: per-flow valid bits make unwritten flows
// read as zero.
module per_flow_delay_jitter_rate_stats
  import pfdjr_pkg::*;
#(
  parameter int unsigned FLOW_COUNT = FlowCountDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // operation, flow_id, now_us, sent_time_us, packet_bytes, interval_us
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // report_flow, rx_rate, tx_rate, avg_delay, avg_jitter
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  localparam int unsigned IdxW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;

  state_t state_r, state_nxt;

  row_t             mem [FLOW_COUNT];
  logic [FLOW_COUNT-1:0] vld_r;
  row_t             rd_r;
  logic             rv_r;
  row_t             row;
  logic [IdxW-1:0]  addr;
  logic             we;
  row_t             wdata;

  op_t              op_r;
  logic [4:0]       flow_r;
  logic [31:0]      x_r;
  logic [15:0]      bytes_r;
  logic [IdxW-1:0]  cnt_r;
  logic [31:0]      ms_r;
  logic signed [34:0] dl_r;
  logic [30:0]      rxr_r;
  logic [30:0]      txr_r;

  logic [QuotW-1:0]   q_r;
  logic [31:0]        rm_r;
  logic [31:0]        dv_r;
  logic [DivCntW-1:0] dc_r;
  logic [32:0]        dtry;
  logic               dge;
  logic [63:0]        ms_prod;

  logic [4:0]   o_flow_r;
  logic [30:0]  o_rx_r;
  logic [30:0]  o_tx_r;
  logic [31:0]  o_dl_r;
  logic [30:0]  o_jt_r;
  logic         o_last_r;

  logic [1:0]   in_op;
  logic [4:0]   in_flow;
  logic [31:0]  in_now;
  logic [31:0]  in_sent;
  logic [15:0]  in_bytes;
  logic [31:0]  in_ivl;
  logic [8:0]   flow_ext;
  logic         flow_ok;
  logic [8:0]   cnt_ext;
  logic         cnt_last;
  logic         accept;

  logic signed [34:0] rq;
  logic signed [34:0] dnew;
  logic signed [34:0] dq;
  logic signed [35:0] dev;
  logic [34:0]        dev_abs;
  logic [33:0]        rx_new;
  logic [33:0]        tx_new;
  logic [30:0]        qsat;

  assign in_op    = in_tdata[1:0];
  assign in_flow  = in_tdata[6:2];
  assign in_now   = in_tdata[38:7];
  assign in_sent  = in_tdata[70:39];
  assign in_bytes = in_tdata[86:71];
  assign in_ivl   = in_tdata[118:87];

  assign accept   = in_tvalid && in_tready;
  assign flow_ext = 9'(flow_r);
  assign flow_ok  = flow_ext < 9'(FLOW_COUNT);
  assign cnt_ext  = 9'(cnt_r);
  assign cnt_last = cnt_r == IdxW'(FLOW_COUNT - 1);
  assign row      = rv_r ? rd_r : '0;
  assign addr     = (op_r == OP_CLOSE) ? cnt_r : flow_ext[IdxW-1:0];

  // interval in ms by reciprocal multiplication
  assign ms_prod = 64'(q_r[31:0]) * 64'(MsRecip);

  // shared divider step
  assign dtry = {rm_r, q_r[QuotW-1]};
  assign dge  = dtry >= {1'b0, dv_r};
  assign qsat = (ms_r == '0) ? '0 :
                ((q_r > QuotW'(RateMax)) ? RateMax : q_r[30:0]);

  // receive arithmetic
  assign rq      = quarter_s(row.dly_avg);
  assign dnew    = row.dly_avg - rq + 35'(signed'(x_r));
  assign dq      = quarter_s(dl_r);
  assign dev     = 36'(signed'(x_r)) - 36'(dq);
  assign dev_abs = dev[35] ? 35'(-dev) : dev[34:0];

  // rate averages
  assign rx_new = row.rx_avg - (row.rx_avg >> 2) + 34'(rxr_r);
  assign tx_new = row.tx_avg - (row.tx_avg >> 2) + 34'(txr_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_CLOSE: state_nxt = ST_MSDIV;
            default:  state_nxt = ST_RD;
          endcase
        end
      end
      ST_MSDIV: state_nxt = ST_RD;
      ST_RD: begin
        if (op_r != OP_CLOSE && !flow_ok) begin
          state_nxt = (op_r == OP_READ) ? ST_OUT : ST_IDLE;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_RX:    state_nxt = ST_RXB;
          OP_TX:    state_nxt = ST_IDLE;
          OP_CLOSE: state_nxt = ST_RDIV;
          OP_READ:  state_nxt = ST_OUT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_RXB:  state_nxt = ST_IDLE;
      ST_RDIV: if (dc_r == '0) state_nxt = ST_TDIV;
      ST_TDIV: if (dc_r == '0) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = (op_r == OP_CLOSE && !cnt_last) ? ST_RD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and table write
  always_comb begin
    in_tready  = state_r == ST_IDLE;
    out_tvalid = state_r == ST_OUT;
    we         = 1'b0;
    wdata      = row;
    unique case (state_r)
      ST_EXEC: begin
        if (op_r == OP_TX) begin
          we           = 1'b1;
          wdata.tx_cnt = add_sat(row.tx_cnt, bytes_r);
        end
      end
      ST_RXB: begin
        we            = 1'b1;
        wdata.dly_avg = dl_r;
        wdata.jit_avg = row.jit_avg - (row.jit_avg >> 2) + dev_abs;
        wdata.rx_cnt  = add_sat(row.rx_cnt, bytes_r);
      end
      ST_UPD: begin
        we            = 1'b1;
        wdata.rx_cnt  = '0;
        wdata.tx_cnt  = '0;
        wdata.rx_avg  = rx_new;
        wdata.tx_avg  = tx_new;
        if (rx_new == '0) wdata.dly_avg = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      rv_r    <= 1'b0;
      dc_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= vld_r[addr];
      if (we) vld_r[addr] <= 1'b1;
      if (state_r == ST_IDLE && accept) cnt_r <= '0;
      if (state_r == ST_OUT && out_tready && op_r == OP_CLOSE && !cnt_last) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_EXEC && op_r == OP_CLOSE) begin
        dc_r <= DivCntW'(QuotW);
      end else if (state_r == ST_RDIV && dc_r == '0) begin
        dc_r <= DivCntW'(QuotW);
      end else if (dc_r != '0) begin
        dc_r <= dc_r - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      op_r    <= op_t'(in_op);
      flow_r  <= in_flow;
      x_r     <= in_now - in_sent;
      bytes_r <= in_bytes;
      q_r     <= QuotW'(in_ivl);
      rm_r    <= '0;
      dv_r    <= 32'(MsPerSec);
    end else if (dc_r != '0) begin
      q_r  <= {q_r[QuotW-2:0], dge};
      rm_r <= dge ? 32'(dtry - {1'b0, dv_r}) : dtry[31:0];
    end else begin
      unique case (state_r)
        ST_MSDIV: begin
          ms_r <= 32'(ms_prod[63:41]);
        end
        ST_EXEC: begin
          if (op_r == OP_CLOSE) begin
            q_r  <= QuotW'(row.rx_cnt) * QuotW'(MsPerSec);
            rm_r <= '0;
            dv_r <= ms_r;
          end
        end
        ST_RDIV: begin
          rxr_r <= qsat;
          q_r   <= QuotW'(row.tx_cnt) * QuotW'(MsPerSec);
          rm_r  <= '0;
        end
        ST_TDIV: begin
          txr_r <= qsat;
        end
        default: ;
      endcase
    end
    if (state_r == ST_EXEC && op_r == OP_RX) dl_r <= dnew;
    if (state_r == ST_RD && op_r == OP_READ && !flow_ok) begin
      o_flow_r <= flow_r;
      o_rx_r   <= '0;
      o_tx_r   <= '0;
      o_dl_r   <= '0;
      o_jt_r   <= '0;
      o_last_r <= 1'b1;
    end
    if (state_r == ST_EXEC && op_r == OP_READ) begin
      o_flow_r <= flow_r;
      o_rx_r   <= sat31(33'(row.rx_avg >> 2));
      o_tx_r   <= sat31(33'(row.tx_avg >> 2));
      o_dl_r   <= rq[31:0];
      o_jt_r   <= sat31(33'(row.jit_avg >> 2));
      o_last_r <= 1'b1;
    end
    if (state_r == ST_UPD) begin
      o_flow_r <= cnt_ext[4:0];
      o_rx_r   <= sat31(33'(rx_new >> 2));
      o_tx_r   <= sat31(33'(tx_new >> 2));
      o_dl_r   <= (rx_new == '0) ? '0 : rq[31:0];
      o_jt_r   <= sat31(33'(row.jit_avg >> 2));
      o_last_r <= cnt_last;
    end
  end

  assign out_tdata = {6'b0, o_jt_r, o_dl_r, o_tx_r, o_rx_r, o_flow_r};
  assign out_tlast = o_last_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a report is pending");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (dc_r != '0) |-> (state_r == ST_MSDIV || state_r == ST_RDIV || state_r == ST_TDIV))
    else $error("divider stepping outside a division state");

  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && op_r == OP_READ) |-> out_tlast)
    else $error("read report without last flag");

  a_rx_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RXB) |-> $past(state_r == ST_EXEC && op_r == OP_RX))
    else $error("receive update without its first step");

endmodule
